// ----- hw/rtl/mlps_pkg.sv -----
// Package for the multi-level priority stack: status and mode codes, field widths.
package mlps_pkg;

  localparam int PRIO_W = 4;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [PRIO_W-1:0] HIGHEST_PRIO_RESET = 4'd15;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_BAD_LEVEL = 2'd3
  } status_t;

endpackage

// ----- hw/rtl/multi_level_priority_stack.sv -----
// Multi-level priority stack: one LIFO per level over a shared linked node memory.
//
// An item is taken when start is high and busy is low; its result appears for one
// cycle with done high and cannot be held off. After accept, a push does one
// read-modify-write of the node and head memories. A pop goes through S_POP_HEAD,
// S_POP_NODE and S_TOP_NODE when its level keeps elements, and adds S_TOP_HEAD when
// it empties that level and another level becomes the top, since the new head must
// be fetched from the head memory before its node is read; a pop that empties the
// stack ends after S_POP_NODE. A rejected item (bad level, full store, pop on empty)
// answers the cycle after start; steps follow one registered read port per memory.
module multi_level_priority_stack #(
  parameter int LEVELS     = 16,
  parameter int CAPACITY   = 256,
  parameter int ELEM_WIDTH = 32,
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic [ELEM_WIDTH-1:0] element,
  input  logic [3:0]            level,
  output logic                  done,
  output logic [1:0]            status,
  output logic [ELEM_WIDTH-1:0] removed_element,
  output logic [3:0]            removed_level,
  output logic [ELEM_WIDTH-1:0] top_element,
  output logic [3:0]            top_level,
  output logic [CW-1:0]         count,
  output logic                  is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int EW = ELEM_WIDTH;
  localparam int PW = mlps_pkg::PRIO_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_HEAD,
    S_POP_NODE,
    S_TOP_HEAD,
    S_TOP_NODE
  } state_t;

  function automatic logic [LW-1:0] top_of(input logic [LEVELS-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (v[i]) r = LW'(i);
    end
    return r;
  endfunction

  // node memory word: {link, data}
  logic [AW+EW-1:0] node_mem [CAPACITY];
  logic [AW-1:0]    head_mem [LEVELS];

  logic [AW+EW-1:0] node_rd;
  logic [AW-1:0]    head_rd;

  logic             node_we;
  logic [AW-1:0]    node_waddr;
  logic [AW+EW-1:0] node_wdata;
  logic [AW-1:0]    node_raddr;
  logic             head_we;
  logic [LW-1:0]    head_waddr;
  logic [AW-1:0]    head_wdata;
  logic [LW-1:0]    head_raddr;

  state_t            state;
  logic [PW-1:0]     highest_priority;
  logic [LEVELS-1:0] nonempty;
  logic [AW-1:0]     free_head;
  logic [CW-1:0]     free_count;
  logic [CW-1:0]     fresh_next;
  logic [CW-1:0]     stored_count;
  logic [LW-1:0]     top_idx;
  logic [EW-1:0]     top_elem;
  logic [LW-1:0]     lvl_q;
  logic [EW-1:0]     elem_q;
  logic [AW-1:0]     pop_node;
  mlps_pkg::status_t result_status;

  logic [AW-1:0]     push_node;
  logic [AW-1:0]     pop_link;
  logic [LEVELS-1:0] nonempty_left;
  logic              level_bad;

  assign push_node     = (free_count != '0) ? free_head : AW'(fresh_next);
  assign pop_link      = node_rd[AW+EW-1:EW];
  assign nonempty_left = nonempty & ~(LEVELS'(1) << top_idx);
  assign level_bad     = (level > highest_priority) || (32'(level) >= LEVELS);

  assign cfg_ready   = 1'b1;
  assign busy        = (state != S_IDLE);
  assign status      = result_status;
  assign top_element = top_elem;
  assign top_level   = PW'(top_idx);
  assign count       = stored_count;
  assign is_empty    = (stored_count == '0);

  always_comb begin
    node_we    = 1'b0;
    node_waddr = push_node;
    node_wdata = {push_node, elem_q};
    node_raddr = free_head;
    head_we    = 1'b0;
    head_waddr = lvl_q;
    head_wdata = push_node;
    head_raddr = (mode == mlps_pkg::MODE_PUSH) ? LW'(level) : top_idx;
    case (state)
      S_PUSH: begin
        node_we    = 1'b1;
        node_waddr = push_node;
        node_wdata = {(nonempty[lvl_q] ? head_rd : push_node), elem_q};
        head_we    = 1'b1;
        head_waddr = lvl_q;
        head_wdata = push_node;
      end
      S_POP_HEAD: begin
        node_raddr = head_rd;
      end
      S_POP_NODE: begin
        node_we    = 1'b1;
        node_waddr = pop_node;
        node_wdata = {free_head, node_rd[EW-1:0]};
        node_raddr = pop_link;
        head_raddr = top_of(nonempty_left);
        if (pop_link != pop_node) begin
          head_we    = 1'b1;
          head_waddr = top_idx;
          head_wdata = pop_link;
        end
      end
      S_TOP_HEAD: begin
        node_raddr = head_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      highest_priority <= mlps_pkg::HIGHEST_PRIO_RESET;
      nonempty         <= '0;
      free_head        <= '0;
      free_count       <= '0;
      fresh_next       <= '0;
      stored_count     <= '0;
      top_idx          <= '0;
      top_elem         <= '0;
      done             <= 1'b0;
      result_status    <= mlps_pkg::ST_OK;
      removed_element  <= '0;
      removed_level    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) highest_priority <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            elem_q          <= element;
            lvl_q           <= LW'(level);
            removed_element <= '0;
            removed_level   <= '0;
            if (mode == mlps_pkg::MODE_PUSH) begin
              if (level_bad) begin
                result_status <= mlps_pkg::ST_BAD_LEVEL;
                done          <= 1'b1;
              end else if (stored_count >= CW'(CAPACITY)) begin
                result_status <= mlps_pkg::ST_PUSH_FULL;
                done          <= 1'b1;
              end else begin
                state <= S_PUSH;
              end
            end else begin
              if (stored_count == '0) begin
                result_status <= mlps_pkg::ST_POP_EMPTY;
                done          <= 1'b1;
              end else begin
                state <= S_POP_HEAD;
              end
            end
          end
        end
        S_PUSH: begin
          if (free_count != '0) begin
            free_head  <= pop_link;
            free_count <= free_count - CW'(1);
          end else begin
            fresh_next <= fresh_next + CW'(1);
          end
          nonempty[lvl_q] <= 1'b1;
          stored_count    <= stored_count + CW'(1);
          if (stored_count == '0 || lvl_q >= top_idx) begin
            top_idx  <= lvl_q;
            top_elem <= elem_q;
          end
          result_status <= mlps_pkg::ST_OK;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_POP_HEAD: begin
          pop_node <= head_rd;
          state    <= S_POP_NODE;
        end
        S_POP_NODE: begin
          removed_element <= node_rd[EW-1:0];
          removed_level   <= PW'(top_idx);
          result_status   <= mlps_pkg::ST_OK;
          free_head       <= pop_node;
          free_count      <= free_count + CW'(1);
          stored_count    <= stored_count - CW'(1);
          if (pop_link != pop_node) begin
            state <= S_TOP_NODE;
          end else begin
            nonempty <= nonempty_left;
            if (nonempty_left == '0) begin
              top_idx  <= '0;
              top_elem <= '0;
              done     <= 1'b1;
              state    <= S_IDLE;
            end else begin
              top_idx <= top_of(nonempty_left);
              state   <= S_TOP_HEAD;
            end
          end
        end
        S_TOP_HEAD: begin
          state <= S_TOP_NODE;
        end
        S_TOP_NODE: begin
          top_elem <= node_rd[EW-1:0];
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_node_balance: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, free_count} + {1'b0, stored_count}) == {1'b0, fresh_next})
    else $error("free and stored counts do not match allocated nodes");

  a_empty_levels: assert property (@(posedge clk) disable iff (rst)
    (stored_count == '0) == (nonempty == '0))
    else $error("level flags disagree with count");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == mlps_pkg::MODE_POP && stored_count == '0)
    |=> (done && result_status == mlps_pkg::ST_POP_EMPTY))
    else $error("pop on empty not flagged");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (top_elem == '0 && top_idx == '0))
    else $error("top fields not cleared when empty");

endmodule
